FILE: design/plr_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Request and status codes, sequencer states and the result word layout
// shared by the positional list modules.
// ----------------------------------------------------------------------------
`default_nettype none

package plr_pkg;

  localparam int POS_W  = 11;  // width of a request position
  localparam int VAL_W  = 32;  // width of a request value and a removed value
  localparam int LEN_W  = 11;  // width of the reported list length
  localparam int STAT_W = 2;

  // Request kinds carried on the input side band.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } plr_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DRAIN,
    ST_PUT,
    ST_DONE
  } plr_state_t;

  typedef struct packed {
    plr_status_t       status;
    logic [VAL_W-1:0]  removed;
    logic [LEN_W-1:0]  length;
  } plr_res_t;

endpackage

`default_nettype wire

FILE: design/plr_ram.sv
// ----------------------------------------------------------------------------
// Positional list entry memory
// Simple dual-port synchronous memory: one write port and one read port
// with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/plr_seq.sv
// ----------------------------------------------------------------------------
// Positional list sequencer
// Checks each request, keeps the entry count and walks the memory one entry
// per cycle to open or close a gap, with the write trailing the read.
// ----------------------------------------------------------------------------
`default_nettype none

module plr_seq #(
  parameter int CAPACITY   = 1024,
  parameter int ELEM_WIDTH = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire logic                          req_kind,
  input  wire logic [plr_pkg::POS_W-1:0]     req_position,
  input  wire logic [plr_pkg::VAL_W-1:0]     req_value,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output plr_pkg::plr_res_t                  res,
  output logic                               mem_we,
  output logic      [AW-1:0]                 mem_waddr,
  output logic      [ELEM_WIDTH-1:0]         mem_wdata,
  output logic                               mem_re,
  output logic      [AW-1:0]                 mem_raddr,
  input  wire logic [ELEM_WIDTH-1:0]         mem_rdata
);

  import plr_pkg::*;

  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  plr_state_t       state, state_next;
  logic [CW-1:0]    count;
  logic             kind;
  logic [AW-1:0]    ins_idx;
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    last_ptr;
  logic             pend_valid;
  logic             pend_first;
  logic [AW-1:0]    pend_addr;
  logic [ELEM_WIDTH-1:0] elem_val;
  plr_status_t      status;
  logic [VAL_W-1:0] removed;

  logic             accept;
  logic [PW-1:0]    pos_ext;
  logic [PW-1:0]    cnt_ext;
  logic             pos_zero;
  logic             ins_bad;
  logic             del_bad;
  logic             full;
  plr_status_t      acc_status;
  logic [POS_W-1:0] pos_m1;
  logic [AW-1:0]    pos_idx;
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    cnt_idx;
  logic             ins_shift;
  logic [63:0]      val64;
  logic [63:0]      rem64;

  // Request check, done in the accepting cycle.
  always_comb begin
    accept   = req_valid && req_ready;
    pos_ext  = PW'(req_position);
    cnt_ext  = PW'(count);
    pos_zero = (req_position == '0);
    ins_bad  = pos_zero || (pos_ext > cnt_ext + PW'(1));
    del_bad  = pos_zero || (pos_ext > cnt_ext);
    full     = (count == CW'(CAPACITY));
    if (req_kind == REQ_DELETE) begin
      acc_status = del_bad ? STAT_RANGE : STAT_OK;
    end else begin
      acc_status = ins_bad ? STAT_RANGE : (full ? STAT_FULL : STAT_OK);
    end
    pos_m1    = req_position - POS_W'(1);
    pos_idx   = AW'(pos_m1);
    cnt_m1    = count - CW'(1);
    cnt_idx   = AW'(cnt_m1);
    ins_shift = (pos_ext <= cnt_ext);
    val64     = {32'd0, req_value};
    rem64     = 64'(mem_rdata);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (acc_status != STAT_OK) begin
            state_next = ST_DONE;
          end else if (req_kind == REQ_DELETE) begin
            state_next = ST_SHIFT;
          end else begin
            state_next = ins_shift ? ST_SHIFT : ST_PUT;
          end
        end
      end
      ST_SHIFT: begin
        if (rd_ptr == last_ptr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = (kind == REQ_DELETE) ? ST_DONE : ST_PUT;
      end
      ST_PUT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready   = (state == ST_IDLE);
    res_valid   = (state == ST_DONE);
    res.status  = status;
    res.removed = removed;
    res.length  = LEN_W'(count);
    mem_re      = (state == ST_SHIFT);
    mem_raddr   = rd_ptr;
    mem_we      = 1'b0;
    mem_waddr   = pend_addr;
    mem_wdata   = mem_rdata;
    if (state == ST_PUT) begin
      mem_we    = 1'b1;
      mem_waddr = ins_idx;
      mem_wdata = elem_val;
    end else if (pend_valid && !pend_first) begin
      mem_we    = 1'b1;
      mem_waddr = (kind == REQ_DELETE) ? pend_addr - AW'(1) : pend_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == ST_SHIFT);
      if (accept && acc_status == STAT_OK) begin
        count <= (req_kind == REQ_DELETE) ? count - CW'(1) : count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr  <= rd_ptr;
    pend_first <= (state == ST_SHIFT) && (kind == REQ_DELETE) && (rd_ptr == ins_idx);
    if (accept) begin
      kind     <= req_kind;
      ins_idx  <= pos_idx;
      elem_val <= val64[ELEM_WIDTH-1:0];
      status   <= acc_status;
      removed  <= '0;
      rd_ptr   <= (req_kind == REQ_DELETE) ? pos_idx : cnt_idx;
      last_ptr <= (req_kind == REQ_DELETE) ? cnt_idx : pos_idx;
    end else if (state == ST_SHIFT) begin
      rd_ptr <= (kind == REQ_DELETE) ? rd_ptr + AW'(1) : rd_ptr - AW'(1);
    end
    if (pend_valid && pend_first) begin
      removed <= rem64[VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Positional list with insert and delete
// Fixed-capacity list in one synchronous memory, edited by 1-based position.
// ----------------------------------------------------------------------------
// Each input word is one request: insert a value at position p (1..count+1),
// moving later entries up, or delete the entry at position p (1..count),
// moving later entries down. Every request returns exactly one output word
// with a status (ok, position out of range, or list full on an insert), the
// removed value for a successful delete (zero otherwise) and the list length
// after the request. Requests are handled one at a time. A rejected request
// skips the memory and goes straight to its result. An insert or a delete
// moves every entry behind position p, so the slowest request shifts the
// whole list. Its speed is set by the entry memory, which moves one entry
// per cycle through its single read port and single write port. A finished
// result sits in an output register, so the next request is taken while the
// previous result still waits downstream.
// The memory needs no clearing after reset: only entries below the count are
// ever read.
`default_nettype none

module positional_list_insert_delete #(
  parameter int CAPACITY   = 1024,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // position[10:0], value[42:11], zero pad
  input  wire logic [0:0]  s_tuser,   // req_type[0]: 0 insert, 1 delete
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // removed_value[31:0], length_after[42:32], pad
  output logic      [1:0]  m_tuser    // status[1:0]
);

  import plr_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic                  res_valid;
  logic                  res_ready;
  plr_res_t              res;
  plr_res_t              out_word;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;

  plr_seq #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (s_tvalid),
    .req_ready    (s_tready),
    .req_kind     (s_tuser[0]),
    .req_position (s_tdata[POS_W-1:0]),
    .req_value    (s_tdata[POS_W+VAL_W-1:POS_W]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  plr_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEM_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register takes a new result whenever it is empty or its
  // current word is being taken in the same cycle.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  always_comb begin
    m_tuser = out_word.status;
    m_tdata = {5'd0, out_word.length, out_word.removed};
  end

  // A request is taken only when the previous one is finished, so ready must
  // drop right after an accepted word.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in progress");

  // A list-full rejection can only be reported with the list at capacity.
  a_full_length: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STAT_FULL) |-> (m_tdata[42:32] == LEN_W'(CAPACITY)))
    else $error("list-full status with a length below capacity");

  // A rejected request never returns a removed value.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata[31:0] == '0))
    else $error("rejected request returned a nonzero removed value");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Positional list testbench
// Self-checking stream test of insert and delete by 1-based list position.
// ----------------------------------------------------------------------------
// Requests go in as words on the slave-side stream, and every result word is
// checked against a queue-based shadow of the list. A short directed pass
// comes first. A long random pass of well-formed edits around moving size
// targets follows, with out-of-range noise mixed in. Both stream sides idle
// at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plr_pkg::*;

  localparam int CAPACITY       = 1024;
  localparam int ELEM_WIDTH     = 32;
  // The slowest request shifts the whole list. On top of that come a long
  // sender gap and a long receiver stall. The limit takes that sum several
  // times over.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = CAPACITY + 16;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;   // position[10:0], value[42:11], zero pad
  logic [0:0]  s_tuser  = '0;   // req_type[0]: 0 insert, 1 delete
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // removed_value[31:0], length_after[42:32], pad
  logic [1:0]  m_tuser;         // status[1:0]

  // Shadow copy of the list contents, front of the list at index 0.
  logic [ELEM_WIDTH-1:0] list_shadow[$];
  // Results predicted for accepted requests, oldest first.
  plr_res_t              pending_results[$];

  int error_count  = 0;
  int insert_count = 0;
  int delete_count = 0;
  int range_count  = 0;
  int full_count   = 0;
  int peak_length  = 0;
  // When set, neither side idles.
  bit no_idle      = 1'b0;

  positional_list_insert_delete #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Applies one request to the shadow list and returns the result it owes.
  // A position is checked first. A valid insert into a full list is refused
  // with the full status and leaves the list alone.
  function automatic plr_res_t apply_list_edit(logic kind, logic [POS_W-1:0] pos,
                                               logic [VAL_W-1:0] val);
    plr_res_t res;
    int       len;
    len         = list_shadow.size();
    res.status  = STAT_OK;
    res.removed = '0;
    if (kind == REQ_INSERT) begin
      if (pos == 0 || pos > len + 1) begin
        res.status = STAT_RANGE;
      end else if (len >= CAPACITY) begin
        res.status = STAT_FULL;
      end else begin
        list_shadow.insert(pos - 1, val[ELEM_WIDTH-1:0]);
      end
    end else begin
      if (pos == 0 || pos > len) begin
        res.status = STAT_RANGE;
      end else begin
        res.removed = VAL_W'(list_shadow[pos - 1]);
        list_shadow.delete(pos - 1);
      end
    end
    res.length = LEN_W'(list_shadow.size());

    case (res.status)
      STAT_RANGE: range_count++;
      STAT_FULL:  full_count++;
      default: begin
        if (kind == REQ_INSERT) insert_count++;
        else delete_count++;
      end
    endcase
    if (list_shadow.size() > peak_length) peak_length = list_shadow.size();
    return res;
  endfunction

  // Sends one request word and records its expected result once the word
  // is taken. Each call starts and ends on a rising edge. Valid stays high
  // from one word to the next when no gap is drawn.
  task automatic send_request(logic kind, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, val, pos};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_list_edit(kind, pos, val));
  endtask

  // Holds the sender back until every owed result has come out.
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result side: random back pressure, and each taken word is compared with
  // the oldest prediction.
  int stall_left = 0;

  always @(posedge clk) begin
    plr_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result word with nothing pending, tdata=%h tuser=%0d",
                 $time, m_tdata, m_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d, got %0d", $time, want.status, m_tuser);
        end
        if (m_tdata[31:0] !== want.removed) begin
          error_count++;
          $display("%0t: removed value expected %h, got %h",
                   $time, want.removed, m_tdata[31:0]);
        end
        if (m_tdata[42:32] !== want.length) begin
          error_count++;
          $display("%0t: length expected %0d, got %0d", $time, want.length, m_tdata[42:32]);
        end
        if (m_tdata[47:43] !== 5'b0) begin
          error_count++;
          $display("%0t: pad bits expected 0, got %b", $time, m_tdata[47:43]);
        end
      end
    end

    if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    m_tready <= (stall_left == 0);
  end

  // Watchdog: gives up when no word moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Edits on an empty and a short list: bad positions on both sides of the
  // valid range, inserts and deletes at the front, middle and end, and
  // extreme values.
  task automatic test_directed_edges();
    send_request(REQ_DELETE, 11'd1,    32'h0000_0000);  // delete on empty list
    send_request(REQ_DELETE, 11'd0,    32'hFFFF_FFFF);
    send_request(REQ_INSERT, 11'd0,    32'h1234_5678);  // position zero
    send_request(REQ_INSERT, 11'd2,    32'h1234_5678);  // one past count+1
    send_request(REQ_INSERT, 11'd1,    32'h7FFF_FFFF);
    send_request(REQ_INSERT, 11'd1,    32'h8000_0000);  // front
    send_request(REQ_INSERT, 11'd3,    32'hFFFF_FFFF);  // end
    send_request(REQ_INSERT, 11'd2,    32'h0000_0000);  // middle
    send_request(REQ_INSERT, 11'd2047, 32'h5555_5555);  // every position bit set
    send_request(REQ_INSERT, 11'd1024, 32'hAAAA_AAAA);
    send_request(REQ_DELETE, 11'd5,    32'h0000_0000);  // one past count
    send_request(REQ_DELETE, 11'd2047, 32'h0000_0000);
    send_request(REQ_DELETE, 11'd2,    32'hFFFF_FFFF);  // middle
    send_request(REQ_INSERT, 11'd4,    32'h0000_0001);  // end
    send_request(REQ_DELETE, 11'd1,    32'h0000_0000);  // front
    send_request(REQ_DELETE, 11'd3,    32'h0000_0000);  // last
    send_request(REQ_DELETE, 11'd1,    32'h0000_0000);
    send_request(REQ_DELETE, 11'd1,    32'h0000_0000);  // now empty
    send_request(REQ_DELETE, 11'd1,    32'h0000_0000);
    send_request(REQ_INSERT, 11'd1,    32'hA5A5_A5A5);
    send_request(REQ_DELETE, 11'd1,    32'hFFFF_FFFF);  // value field ignored
    wait_results_drained();
  endtask

  // One random request steered toward a target length. Most requests are
  // valid edits. The rest are positions just outside the range or fully
  // random words.
  task automatic random_edit(int target);
    int   len;
    int   roll;
    logic kind;
    logic [POS_W-1:0] pos;
    len  = list_shadow.size();
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      kind = 1'($urandom_range(0, 1));
      pos  = POS_W'($urandom_range(0, 2047));
    end else if (roll < 16) begin
      kind = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0) pos = '0;
      else pos = (kind == REQ_INSERT) ? POS_W'(len + 2) : POS_W'(len + 1);
    end else begin
      if (len == 0) kind = REQ_INSERT;
      else if (len < target) kind = ($urandom_range(0, 3) != 0) ? REQ_INSERT : REQ_DELETE;
      else if (len > target) kind = ($urandom_range(0, 3) != 0) ? REQ_DELETE : REQ_INSERT;
      else kind = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 9);
      if (kind == REQ_INSERT) begin
        if (roll == 0) pos = POS_W'(1);
        else if (roll == 1) pos = POS_W'(len + 1);
        else pos = POS_W'($urandom_range(1, len + 1));
      end else begin
        if (roll == 0) pos = POS_W'(1);
        else if (roll == 1) pos = POS_W'(len);
        else pos = POS_W'($urandom_range(1, len));
      end
    end
    send_request(kind, pos, $urandom());
  endtask

  // Random edits in segments. Each segment has its own length target, mostly
  // short lists and now and then a few hundred entries. Some segments run
  // with no idling, and some end with the sender waiting for all results.
  task automatic test_random_edits(int item_total);
    int sent;
    int target;
    int seg;
    sent = 0;
    while (sent < item_total) begin
      target  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 40);
      no_idle = ($urandom_range(0, 5) == 0);
      for (seg = 0; seg < 40 && sent < item_total; seg++) begin
        random_edit(target);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_results_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_random_edits(560);

    wait_results_drained();
    // Let a late or stray result word show itself before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d inserts, %0d deletes, %0d out-of-range and %0d full-list refusals.",
             insert_count, delete_count, range_count, full_count);
    $display("The list reached %0d of %0d entries; %0d result words were left unanswered.",
             peak_length, CAPACITY, pending_results.size());
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: positional_list_insert_delete.f
design/plr_pkg.sv
design/plr_ram.sv
design/plr_seq.sv
design/positional_list_insert_delete.sv
test/testbench.sv
